>>> rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned FrameLen     = 25;
  localparam int unsigned WinDepth     = FrameLen - 1;
  localparam int unsigned PayloadBytes = 22;
  localparam int unsigned NumCh        = 16;
  localparam int unsigned ChBits       = 11;
  localparam int unsigned CntW         = 5;
  localparam int unsigned ChIdxW       = 4;
  localparam int unsigned PaddrW       = 3;

  localparam logic [7:0] StartCode = 8'h0F;
  localparam logic [7:0] EndCode   = 8'h00;

  localparam logic [CntW-1:0]   FrameLenCnt = CntW'(FrameLen);
  localparam logic [ChIdxW-1:0] LastCh      = ChIdxW'(NumCh - 1);

  localparam logic RegClampLow  = 1'b0;
  localparam logic RegClampHigh = 1'b1;

  localparam logic [ChBits-1:0] ClampLowRst  = ChBits'(306);
  localparam logic [ChBits-1:0] ClampHighRst = ChBits'(1693);

  typedef struct packed {
    logic [7:0]                  flags;
    logic [PayloadBytes*8-1:0]   payload;
  } frame_t;

endpackage

>>> rtl/sfd_front.sv
module sfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     rx_byte_i,
  output logic           frame_valid_o,
  output sfd_pkg::frame_t frame_o
);
  import sfd_pkg::*;

  logic [7:0]      win_q [WinDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hit;

  assign hit = accept_i && (cnt_q >= FrameLenCnt - CntW'(1)) &&
               (win_q[0] == StartCode) && (rx_byte_i == EndCode);

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      if (hit) begin
        cnt_d = '0;
      end else if (cnt_q < FrameLenCnt) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < PayloadBytes; j++) begin
      frame_o.payload[j*8 +: 8] = win_q[j+1];
    end
    frame_o.flags = win_q[WinDepth-1];
  end

  assign frame_valid_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int k = 0; k < WinDepth - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[WinDepth-1] <= rx_byte_i;
    end
  end

endmodule

>>> rtl/sfd_fifo.sv
module sfd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfd_pkg::frame_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sfd_pkg::frame_t rdata_o
);
  import sfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/sfd_back.sv
module sfd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fq_empty_i,
  input  sfd_pkg::frame_t            fq_data_i,
  output logic                       fq_pop_o,
  input  logic [sfd_pkg::ChBits-1:0] clamp_low_i,
  input  logic [sfd_pkg::ChBits-1:0] clamp_high_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [3:0]                 channel_index_o,
  output logic [10:0]                channel_value_o,
  output logic [7:0]                 flag_byte_o,
  output logic                       frame_last_o
);
  import sfd_pkg::*;

  logic [ChIdxW-1:0] ch_q;
  logic              out_valid_q;
  logic              load;
  logic [ChBits-1:0] raw, clamped;

  assign load     = !fq_empty_i && (!out_valid_q || pop_i);
  assign fq_pop_o = load && (ch_q == LastCh);
  assign raw      = fq_data_i.payload[ch_q*ChBits +: ChBits];

  always_comb begin
    if (raw <= clamp_low_i) begin
      clamped = clamp_low_i;
    end else if (raw >= clamp_high_i) begin
      clamped = clamp_high_i;
    end else begin
      clamped = raw;
    end
  end

  assign empty_o = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        ch_q        <= ch_q + ChIdxW'(1);
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      channel_index_o <= ch_q;
      channel_value_o <= clamped;
      flag_byte_o     <= fq_data_i.flags;
      frame_last_o    <= (ch_q == LastCh);
    end
  end

endmodule

>>> rtl/sbus_frame_decoder.sv
// Serial-bus frame decoder, sixteen channels.
// Input queue side: present rx_byte_i with push; a byte is taken on a clock
// edge where push is high and full is low, so one byte per cycle while not full.
// A 25-byte window is checked on every byte; a frame needs 25 bytes since the
// previous frame, start code 0x0F oldest and end code 0x00 newest.
// Result queue side: while empty is low the oldest result is on the result
// ports; pop takes it. Each frame yields sixteen items, channels 0..15, the
// last one marked by frame_last_o.
// The closing byte writes the frame into the frame queue, from which channel 0 is
// loaded into the output registers, then one channel per cycle while each is popped.
// Frames wait in a two-entry frame queue; full rises only when that queue is
// full, so a stalled receiver holds results in place and back-pressures input
// after two frames are pending.
// Reset clears the byte count, queue and output valid; clamp limits return to
// 306 and 1693. Limits are written over the APB port at 0x0 and 0x4.
module sbus_frame_decoder #(
  parameter int unsigned FqDepth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 rx_byte_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [3:0]                 channel_index_o,
  output logic [10:0]                channel_value_o,
  output logic [7:0]                 flag_byte_o,
  output logic                       frame_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sfd_pkg::*;

  logic              accept;
  logic              frame_valid;
  frame_t            frame_in, frame_out;
  logic              fq_full, fq_empty, fq_pop;
  logic [ChBits-1:0] clamp_low_q, clamp_high_q;
  logic              cfg_wr;

  assign full   = fq_full;
  assign accept = push && !fq_full;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      RegClampLow:  prdata = 32'(clamp_low_q);
      RegClampHigh: prdata = 32'(clamp_high_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_low_q  <= ClampLowRst;
      clamp_high_q <= ClampHighRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegClampLow) begin
        clamp_low_q <= pwdata[ChBits-1:0];
      end else begin
        clamp_high_q <= pwdata[ChBits-1:0];
      end
    end
  end

  sfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame_in)
  );

  sfd_fifo #(
    .Depth (FqDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_valid),
    .wdata_i (frame_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .rdata_o (frame_out)
  );

  sfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fq_empty_i      (fq_empty),
    .fq_data_i       (frame_out),
    .fq_pop_o        (fq_pop),
    .clamp_low_i     (clamp_low_q),
    .clamp_high_i    (clamp_high_q),
    .empty_o         (empty),
    .pop_i           (pop),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .flag_byte_o     (flag_byte_o),
    .frame_last_o    (frame_last_o)
  );

endmodule

>>> test/sfd_channel_monitor.sv
module sfd_channel_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [3:0]                 channel_index_o,
  input  logic [10:0]                channel_value_o,
  input  logic [7:0]                 flag_byte_o,
  input  logic                       frame_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       end_check_i,
  output int                         errors_o,
  output int                         pending_o
);
  import sfd_pkg::*;

  typedef struct packed {
    logic [ChIdxW-1:0] index;
    logic [ChBits-1:0] value;
    logic [7:0]        flags;
    logic              last;
  } channel_item_t;

  logic [7:0]        window [FrameLen];
  logic [CntW-1:0]   since_frame;
  logic [ChBits-1:0] clamp_lo;
  logic [ChBits-1:0] clamp_hi;
  channel_item_t     expected_channels [$];
  int                fail_cnt;
  bit                end_seen;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    fail_cnt++;
  endtask

  task automatic shift_in_byte(input logic [7:0] b);
    logic [PayloadBytes*8-1:0] payload;
    logic [ChBits-1:0]         raw;
    channel_item_t             item;
    for (int i = 0; i < FrameLen - 1; i++) window[i] = window[i+1];
    window[FrameLen-1] = b;
    if (since_frame != FrameLenCnt) since_frame++;
    if (since_frame == FrameLenCnt && window[0] == StartCode &&
        window[FrameLen-1] == EndCode) begin
      since_frame = '0;
      for (int i = 0; i < PayloadBytes; i++) payload[i*8 +: 8] = window[i+1];
      for (int ch = 0; ch < NumCh; ch++) begin
        raw = payload[ch*ChBits +: ChBits];
        item.index = ChIdxW'(ch);
        if (raw <= clamp_lo) begin
          item.value = clamp_lo;
        end else if (raw >= clamp_hi) begin
          item.value = clamp_hi;
        end else begin
          item.value = raw;
        end
        item.flags = window[PayloadBytes+1];
        item.last  = (item.index == LastCh);
        expected_channels.push_back(item);
      end
    end
  endtask

  task automatic check_channel();
    channel_item_t want;
    if (expected_channels.size() == 0) begin
      report($sformatf("channel %0d value %0d with nothing expected",
                       channel_index_o, channel_value_o));
      return;
    end
    want = expected_channels.pop_front();
    if (channel_index_o !== want.index)
      report($sformatf("channel_index %0d, want %0d", channel_index_o, want.index));
    if (channel_value_o !== want.value)
      report($sformatf("ch %0d channel_value %0d, want %0d",
                       want.index, channel_value_o, want.value));
    if (flag_byte_o !== want.flags)
      report($sformatf("ch %0d flag_byte %h, want %h", want.index, flag_byte_o, want.flags));
    if (frame_last_o !== want.last)
      report($sformatf("ch %0d frame_last %b, want %b", want.index, frame_last_o, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_frame = '0;
      clamp_lo    = ClampLowRst;
      clamp_hi    = ClampHighRst;
      expected_channels.delete();
      fail_cnt    = 0;
      end_seen    = 1'b0;
      errors_o    <= 0;
      pending_o   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PaddrW-1:2] == RegClampLow) clamp_lo = pwdata[ChBits-1:0];
        if (paddr[PaddrW-1:2] == RegClampHigh) clamp_hi = pwdata[ChBits-1:0];
      end
      if (pop && !empty) check_channel();
      if (push && !full) shift_in_byte(rx_byte_i);
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_channels.size() != 0)
          report($sformatf("%0d channel items never arrived", expected_channels.size()));
      end
      errors_o  <= fail_cnt;
      pending_o <= expected_channels.size();
    end
  end

endmodule

>>> test/testbench.sv
module testbench;
  import sfd_pkg::*;

  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 8;
  localparam int IdleLimit    = 1000;
  localparam int NumPhases    = 8;
  localparam int PhaseBytes   = 25;

  localparam logic [PaddrW-1:0] AddrClampLow  = {RegClampLow, 2'b00};
  localparam logic [PaddrW-1:0] AddrClampHigh = {RegClampHigh, 2'b00};

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [7:0]        rx_byte_i;
  logic              empty;
  logic              pop;
  logic [3:0]        channel_index_o;
  logic [10:0]       channel_value_o;
  logic [7:0]        flag_byte_o;
  logic              frame_last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              end_check;
  int                errors;
  int                pending;
  int                hold_req;
  int                idle_cycles;
  int                bytes_sent;
  int                burst_left;
  bit                no_gaps;
  logic [ChBits-1:0] cur_lo;
  logic [ChBits-1:0] cur_hi;

  sbus_frame_decoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .rx_byte_i(rx_byte_i),
    .empty(empty), .pop(pop),
    .channel_index_o(channel_index_o), .channel_value_o(channel_value_o),
    .flag_byte_o(flag_byte_o), .frame_last_o(frame_last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sfd_channel_monitor u_monitor (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .rx_byte_i(rx_byte_i),
    .empty(empty), .pop(pop),
    .channel_index_o(channel_index_o), .channel_value_o(channel_value_o),
    .flag_byte_o(flag_byte_o), .frame_last_o(frame_last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .end_check_i(end_check), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: pop pattern picked at random from four modes, long hold-off on request
  initial begin
    int hold_served;
    int cyc;
    int mode;
    hold_served = 0;
    cyc = 0;
    mode = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req != hold_served) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_served++;
      end else begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= (cyc % 8) < 5;
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
        cyc++;
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_byte_i <= b;
    push      <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_frame(input logic [7:0] start_b, input logic [PayloadBytes*8-1:0] pl,
                            input logic [7:0] flags, input logic [7:0] end_b,
                            input int nbytes);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0) begin
        b = start_b;
      end else if (i <= PayloadBytes) begin
        b = pl[(i-1)*8 +: 8];
      end else if (i == PayloadBytes + 1) begin
        b = flags;
      end else begin
        b = end_b;
      end
      push_byte(b);
    end
  endtask

  function automatic logic [PayloadBytes*8-1:0] random_payload();
    logic [PayloadBytes*8-1:0] pl;
    logic [ChBits-1:0]         v;
    for (int ch = 0; ch < NumCh; ch++) begin
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        2:       v = cur_lo;
        3:       v = cur_lo + 1'b1;
        4:       v = cur_hi;
        5:       v = cur_hi - 1'b1;
        default: v = ChBits'($urandom_range(0, 2047));
      endcase
      pl[ch*ChBits +: ChBits] = v;
    end
    return pl;
  endfunction

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [ChBits-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {21'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drop push and drain every pending channel item
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int               phase_start;
    int               kind;
    logic [7:0]       start_b;
    logic [ChBits-1:0] new_lo;
    logic [ChBits-1:0] new_hi;
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    rx_byte_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    end_check  <= 1'b0;
    hold_req   <= 0;
    bytes_sent = 0;
    burst_left = 0;
    no_gaps    = 1'b0;
    cur_lo     = ClampLowRst;
    cur_hi     = ClampHighRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_byte(StartCode);
    push_byte(EndCode);
    push_byte(8'hFF);
    send_frame(StartCode, '0, 8'hFF, EndCode, FrameLen);
    send_frame(StartCode, '1, 8'h00, EndCode, FrameLen);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        settle();
        case (phase)
          1:       begin new_lo = 11'd0;    new_hi = 11'd2047; end
          2:       begin new_lo = 11'd2047; new_hi = 11'd0;    end
          3:       begin new_lo = 11'd0;    new_hi = 11'd0;    end
          4:       begin new_lo = 11'd2047; new_hi = 11'd2047; end
          5:       begin new_lo = 11'd1000; new_hi = 11'd500;  end
          6:       begin
            new_lo = ChBits'($urandom_range(0, 2047));
            new_hi = ChBits'($urandom_range(0, 2047));
          end
          default: begin new_lo = ClampLowRst; new_hi = ClampHighRst; end
        endcase
        apb_write(AddrClampLow, new_lo);
        apb_write(AddrClampHigh, new_hi);
        cur_lo = new_lo;
        cur_hi = new_hi;
      end
      if (phase == 2) begin
        // hold the receiver off while frames keep coming, so the input stalls
        hold_req <= hold_req + 1;
        no_gaps = 1'b1;
        repeat (3) send_frame(StartCode, random_payload(), 8'($urandom), EndCode, FrameLen);
      end
      no_gaps = (phase == 4);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          send_frame(StartCode, random_payload(), 8'($urandom), EndCode, FrameLen);
        end else if (kind < 65) begin
          send_frame(StartCode, random_payload(), 8'($urandom), 8'($urandom_range(1, 255)),
                     FrameLen);
        end else if (kind < 75) begin
          start_b = 8'($urandom_range(16, 255));
          send_frame(start_b, random_payload(), 8'($urandom), EndCode, FrameLen);
        end else if (kind < 85) begin
          send_frame(StartCode, random_payload(), 8'($urandom), EndCode,
                     $urandom_range(1, FrameLen - 1));
        end else begin
          repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 3))
              0:       push_byte(StartCode);
              1:       push_byte(EndCode);
              default: push_byte(8'($urandom));
            endcase
          end
        end
      end
    end

    settle();
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
